// ----- rtl/srpb_pkg.sv -----
// Shared types, constants and helper functions of the scrambled RGB565 pixel blender.
package srpb_pkg;

    // Scramble masks, chosen by column parity
    localparam logic [15:0] MASK_ODD  = 16'hFFE7;
    localparam logic [15:0] MASK_EVEN = 16'hF3E7;

    // Full-scale weight; a blended channel is floor(sum / FULL_WEIGHT)
    localparam int FULL_WEIGHT = 200;

    // Width of a weighted channel sum: 2 * 255 * 255 fits in 17 bits
    localparam int SUM_W = 17;

    // Divide by 200 as (sum >> 3) / 25; the quotient by 25 is taken as a
    // multiply by ceil(2^19 / 25) and a right shift, exact for a 14-bit dividend.
    localparam int          RECIP_SHIFT = 19;
    localparam logic [14:0] RECIP_25    = 15'd20972;
    localparam int          DIVIDEND_W  = SUM_W - 3;
    localparam int          PROD_W      = DIVIDEND_W + 15;
    localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // One input pixel transaction
    typedef struct packed {
        logic [15:0] frame_word;
        logic        column_odd;
        logic [7:0]  stored_red;
        logic [7:0]  stored_green;
        logic [7:0]  stored_blue;
        logic [7:0]  overlay_red;
        logic [7:0]  overlay_green;
        logic [7:0]  overlay_blue;
        logic [7:0]  live_weight;
        logic [7:0]  overlay_weight;
    } pixel_t;

    // After live colour selection
    typedef struct packed {
        logic [7:0] live_red;
        logic [7:0] live_green;
        logic [7:0] live_blue;
        logic [7:0] overlay_red;
        logic [7:0] overlay_green;
        logic [7:0] overlay_blue;
        logic [7:0] live_weight;
        logic [7:0] overlay_weight;
        logic       column_odd;
        logic       decoded;
    } live_t;

    // After the weighted sums
    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [7:0]       live_red;
        logic [7:0]       live_green;
        logic [7:0]       live_blue;
        logic             column_odd;
        logic             decoded;
    } sum_t;

    // One result transaction
    typedef struct packed {
        logic [15:0] pixel_word;
        logic [7:0]  live_red;
        logic [7:0]  live_green;
        logic [7:0]  live_blue;
        logic        live_valid;
    } result_t;

    function automatic logic [15:0] scramble_mask(input logic column_odd);
        return column_odd ? MASK_ODD : MASK_EVEN;
    endfunction

    function automatic logic [15:0] pack565(input logic [7:0] red, input logic [7:0] green,
                                            input logic [7:0] blue);
        return {blue[7:3], green[7:2], red[7:3]};
    endfunction

    // floor(sum / 200), saturated to 255
    function automatic logic [7:0] div_full_weight(input logic [SUM_W-1:0] sum);
        logic [DIVIDEND_W-1:0] dividend;
        logic [PROD_W-1:0]     prod;
        logic [QUOT_W-1:0]     quot;
        dividend = sum[SUM_W-1:3];
        prod     = PROD_W'(dividend) * PROD_W'(RECIP_25);
        quot     = prod[PROD_W-1:RECIP_SHIFT];
        return (quot > QUOT_W'(CHAN_MAX)) ? CHAN_MAX : quot[7:0];
    endfunction

endpackage

// ----- rtl/srpb_pixel_in_if.sv -----
// Input pixel channel: valid/ready handshake with the pixel payload.
interface srpb_pixel_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_word;
    logic        column_odd;
    logic [7:0]  stored_red;
    logic [7:0]  stored_green;
    logic [7:0]  stored_blue;
    logic [7:0]  overlay_red;
    logic [7:0]  overlay_green;
    logic [7:0]  overlay_blue;
    logic [7:0]  live_weight;
    logic [7:0]  overlay_weight;

    modport source (
        output valid, frame_word, column_odd, stored_red, stored_green, stored_blue,
               overlay_red, overlay_green, overlay_blue, live_weight, overlay_weight,
        input  ready
    );
    modport sink (
        input  valid, frame_word, column_odd, stored_red, stored_green, stored_blue,
               overlay_red, overlay_green, overlay_blue, live_weight, overlay_weight,
        output ready
    );
endinterface

// ----- rtl/srpb_pixel_out_if.sv -----
// Output pixel channel: valid/ready handshake with the result payload.
interface srpb_pixel_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_word;
    logic [7:0]  live_red;
    logic [7:0]  live_green;
    logic [7:0]  live_blue;
    logic        live_valid;

    modport source (
        output valid, pixel_word, live_red, live_green, live_blue, live_valid,
        input  ready
    );
    modport sink (
        input  valid, pixel_word, live_red, live_green, live_blue, live_valid,
        output ready
    );
endinterface

// ----- rtl/srpb_decode.sv -----
// Stage 1: descramble the frame word and select the live colour.
module srpb_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                source_mode,
    input  logic                up_valid,
    output logic                up_ready,
    input  srpb_pkg::pixel_t    up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output srpb_pkg::live_t     dn_data
);

    logic              valid_reg;
    srpb_pkg::live_t   data_reg;
    srpb_pkg::live_t   data_next;
    logic [15:0]       plain;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        plain = up_data.frame_word ^ srpb_pkg::scramble_mask(up_data.column_odd);
        data_next.overlay_red    = up_data.overlay_red;
        data_next.overlay_green  = up_data.overlay_green;
        data_next.overlay_blue   = up_data.overlay_blue;
        data_next.live_weight    = up_data.live_weight;
        data_next.overlay_weight = up_data.overlay_weight;
        data_next.column_odd     = up_data.column_odd;
        data_next.decoded        = !source_mode;
        if (!source_mode)
        begin
            data_next.live_red   = {plain[4:0], 3'b000};
            data_next.live_green = {plain[10:5], 2'b00};
            data_next.live_blue  = {plain[15:11], 3'b000};
        end
        else
        begin
            data_next.live_red   = up_data.stored_red;
            data_next.live_green = up_data.stored_green;
            data_next.live_blue  = up_data.stored_blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- rtl/srpb_mix.sv -----
// Stage 2: weighted channel sums of live and overlay colours.
module srpb_mix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  srpb_pkg::live_t     up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output srpb_pkg::sum_t      dn_data
);

    logic             valid_reg;
    srpb_pkg::sum_t   data_reg;
    srpb_pkg::sum_t   data_next;

    function automatic logic [srpb_pkg::SUM_W-1:0] wsum(input logic [7:0] live,
                                                        input logic [7:0] over,
                                                        input logic [7:0] wl,
                                                        input logic [7:0] wm);
        logic [15:0] plive;
        logic [15:0] pover;
        plive = 16'(live) * 16'(wl);
        pover = 16'(over) * 16'(wm);
        return srpb_pkg::SUM_W'(plive) + srpb_pkg::SUM_W'(pover);
    endfunction

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        data_next.sum_red    = wsum(up_data.live_red, up_data.overlay_red,
                                    up_data.live_weight, up_data.overlay_weight);
        data_next.sum_green  = wsum(up_data.live_green, up_data.overlay_green,
                                    up_data.live_weight, up_data.overlay_weight);
        data_next.sum_blue   = wsum(up_data.live_blue, up_data.overlay_blue,
                                    up_data.live_weight, up_data.overlay_weight);
        data_next.live_red   = up_data.live_red;
        data_next.live_green = up_data.live_green;
        data_next.live_blue  = up_data.live_blue;
        data_next.column_odd = up_data.column_odd;
        data_next.decoded    = up_data.decoded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- rtl/srpb_scale.sv -----
// Stage 3: divide by full weight, saturate, repack and rescramble; output register.
module srpb_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  srpb_pkg::sum_t      up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output srpb_pkg::result_t   dn_data
);

    logic                valid_reg;
    srpb_pkg::result_t   data_reg;
    srpb_pkg::result_t   data_next;
    logic [7:0]          mix_red;
    logic [7:0]          mix_green;
    logic [7:0]          mix_blue;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        mix_red   = srpb_pkg::div_full_weight(up_data.sum_red);
        mix_green = srpb_pkg::div_full_weight(up_data.sum_green);
        mix_blue  = srpb_pkg::div_full_weight(up_data.sum_blue);
        data_next.pixel_word = srpb_pkg::pack565(mix_red, mix_green, mix_blue)
                               ^ srpb_pkg::scramble_mask(up_data.column_odd);
        // Zero the live colour when it came from the stored inputs
        data_next.live_red   = up_data.decoded ? up_data.live_red : 8'd0;
        data_next.live_green = up_data.decoded ? up_data.live_green : 8'd0;
        data_next.live_blue  = up_data.decoded ? up_data.live_blue : 8'd0;
        data_next.live_valid = up_data.decoded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- rtl/scrambled_rgb565_pixel_blender_top.sv -----
// Top level of the scrambled RGB565 pixel blender.
//
// One pixel transaction in, one result transaction out, at one pixel per clock
// while the output is not stalled. Each pixel passes three register stages:
// descramble and live colour selection, the weighted channel sums (two 8x8
// multiplies per channel), and the exact divide by 200 (a reciprocal multiply)
// with saturation, repack and rescramble into the output register. A pixel
// accepted at the input is registered in the decode, mix and scale stages in
// that order before its result is valid. Each stage holds its transaction while
// the stage after it is full and stalled, so an empty stage anywhere lets a new
// pixel in even while a finished result waits on the output; with all three
// stages full and the output stalled, ready drops. The scramble mask is 0xFFE7
// on odd columns and 0xF3E7 on even ones. source_mode selects where the live
// colour comes from: 0 unpacks it from the descrambled frame word and also
// presents it on live_red/green/blue with live_valid high; 1 takes the
// stored_* inputs and drives the live outputs and live_valid to zero. Weights
// of 200/0 and 0/200 need no special handling: the general blend already
// returns the live or the overlay pixel exactly, so mode 0 with weights 200/0
// gives the frame word back unchanged. Write source_mode only while the
// pipeline is empty; it is sampled as a pixel enters the first stage.
module scrambled_rgb565_pixel_blender_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    srpb_pixel_in_if.sink       pix_in,
    srpb_pixel_out_if.source    pix_out
);

    logic                source_mode_reg;
    logic                source_mode_next;

    srpb_pkg::pixel_t    in_data;

    logic                s1_valid;
    logic                s1_ready;
    srpb_pkg::live_t     s1_data;

    logic                s2_valid;
    logic                s2_ready;
    srpb_pkg::sum_t      s2_data;

    srpb_pkg::result_t   out_data;

    // Configuration register: take the write, hold otherwise
    assign source_mode_next = cfg_we ? cfg_wdata : source_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            source_mode_reg <= 1'b0;
        else
            source_mode_reg <= source_mode_next;
    end

    // Gather the input fields into one payload
    always_comb
    begin
        in_data.frame_word     = pix_in.frame_word;
        in_data.column_odd     = pix_in.column_odd;
        in_data.stored_red     = pix_in.stored_red;
        in_data.stored_green   = pix_in.stored_green;
        in_data.stored_blue    = pix_in.stored_blue;
        in_data.overlay_red    = pix_in.overlay_red;
        in_data.overlay_green  = pix_in.overlay_green;
        in_data.overlay_blue   = pix_in.overlay_blue;
        in_data.live_weight    = pix_in.live_weight;
        in_data.overlay_weight = pix_in.overlay_weight;
    end

    // Stage 1: descramble, select live colour
    srpb_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .source_mode (source_mode_reg),
        .up_valid    (pix_in.valid),
        .up_ready    (pix_in.ready),
        .up_data     (in_data),
        .dn_valid    (s1_valid),
        .dn_ready    (s1_ready),
        .dn_data     (s1_data)
    );

    // Stage 2: weighted sums
    srpb_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    // Stage 3: divide, saturate, repack, rescramble
    srpb_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (pix_out.valid),
        .dn_ready (pix_out.ready),
        .dn_data  (out_data)
    );

    // Drive the result fields
    assign pix_out.pixel_word = out_data.pixel_word;
    assign pix_out.live_red   = out_data.live_red;
    assign pix_out.live_green = out_data.live_green;
    assign pix_out.live_blue  = out_data.live_blue;
    assign pix_out.live_valid = out_data.live_valid;

`ifndef NO_ASSERTIONS
    // A full, stalled pipeline must refuse new pixels
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s2_valid && pix_out.valid && !pix_out.ready) |-> !pix_in.ready)
        else $error("input accepted while all stages are full and stalled");

    // Results from the stored colour carry no live colour
    a_live_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && !pix_out.live_valid) |->
            (pix_out.live_red == 8'd0 && pix_out.live_green == 8'd0 &&
             pix_out.live_blue == 8'd0))
        else $error("live colour nonzero on a stored-colour result");

    // A configuration write lands in the mode register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (source_mode_reg == $past(cfg_wdata)))
        else $error("source_mode write lost");
`endif

endmodule
